// File: src/tocx_pkg.sv
// ----------------------------------------------------------------------------
// tocx_pkg
// Types and constants shared by the three-operand cpu execute block
// ----------------------------------------------------------------------------
package tocx_pkg;

   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 12;
   localparam int ADDR_SPAN = 4096;
   localparam int SEL_W     = 4;
   localparam int OP_W      = 8;
   localparam int IMM_W     = 12;

   // operand slots read from the register file for every instruction
   localparam int NUM_OPND = 4;
   localparam int OPND_A   = 0;
   localparam int OPND_B   = 1;
   localparam int OPND_C   = 2;
   localparam int OPND_D   = 3;

   // fixed register numbers
   localparam logic [SEL_W-1:0] REG_ZERO = 4'd0;
   localparam logic [SEL_W-1:0] REG_IMM1 = 4'd1;
   localparam logic [SEL_W-1:0] REG_IMM2 = 4'd2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 8'd0,
      OP_SUB  = 8'd1,
      OP_MAC  = 8'd2,
      OP_AND  = 8'd3,
      OP_OR   = 8'd4,
      OP_XOR  = 8'd5,
      OP_SLL  = 8'd6,
      OP_SRA  = 8'd7,
      OP_SRL  = 8'd8,
      OP_BEQ  = 8'd9,
      OP_BNE  = 8'd10,
      OP_BLT  = 8'd11,
      OP_BGT  = 8'd12,
      OP_BLE  = 8'd13,
      OP_BGE  = 8'd14,
      OP_JAL  = 8'd15,
      OP_LW   = 8'd16,
      OP_SW   = 8'd17,
      OP_RETI = 8'd18,
      OP_IN   = 8'd19,
      OP_OUT  = 8'd20,
      OP_HALT = 8'd21
   } op_code_type;

   typedef struct packed {
      logic [OP_W-1:0]  op_code;
      logic [SEL_W-1:0] dest_sel;
      logic [SEL_W-1:0] src_a_sel;
      logic [SEL_W-1:0] src_b_sel;
      logic [SEL_W-1:0] src_c_sel;
      logic [IMM_W-1:0] imm_first;
      logic [IMM_W-1:0] imm_second;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        next_pc;
      logic                     halted;
      logic                     reg_written;
      logic [SEL_W-1:0]         written_reg;
      logic signed [DATA_W-1:0] written_value;
      logic                     mem_written;
      logic [ADDR_W-1:0]        mem_address;
      logic                     io_request;
      logic                     bad_opcode;
   } rsp_payload_type;

endpackage

// File: src/tocx_ram.sv
// ----------------------------------------------------------------------------
// tocx_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module tocx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/three_operand_cpu_execute.sv
// ----------------------------------------------------------------------------
// three_operand_cpu_execute
// Execute stage of a small three-operand core with register file and data memory
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | req_payload  (decoded instr)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_payload  (retire result)
//
// one instruction per cycle sustained unless rsp stalls or a load hazard holds s1
// a load followed by an instruction reading its destination stalls it until the
//   load retires (the load data only appears at the data memory's registered read port)
// after reset the data memory is swept to zero, one word per cycle, over the
//   first min(MEM_DEPTH, 4096) words; req_ready stays low during the sweep
// a stalled rsp holds the pipe; req_ready drops when s1 is full and cannot advance
//
// pipeline
//   s1 : operands from the register file read port (issued on accept), plus
//        forwarding; alu, branch, pc/halt update, store write, load address
//   s2 : result register; load data added to the third operand, register
//        file write on rsp transaction
// ----------------------------------------------------------------------------
module three_operand_cpu_execute
   import tocx_pkg::*;
#(
   parameter int MEM_DEPTH = 4096,
   parameter int REG_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int RF_AW     = $clog2(REG_COUNT);
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CLR_DEPTH = (MEM_DEPTH < ADDR_SPAN) ? MEM_DEPTH : ADDR_SPAN;
   localparam int MOD_SHIFT = 24;
   localparam int MOD_RECIP = (2 ** MOD_SHIFT) / MEM_DEPTH;
   localparam int PROD_W    = MOD_SHIFT + ADDR_W;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [MEM_AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0]      pc_ff, pc_in;
   logic                   halt_ff, halt_in;
   logic [REG_COUNT-1:0]   rf_vld_ff;

   // stage payloads
   req_payload_type        s1_req_ff;
   rsp_payload_type        s2_rsp_ff, s2_rsp_in;
   logic                   s2_is_load_ff, s2_is_load_in;

   // per-operand forwarding captured at the register file read
   logic                   fwd_ff     [NUM_OPND];
   logic [DATA_W-1:0]      fwd_val_ff [NUM_OPND];
   logic                   rdvld_ff   [NUM_OPND];

   logic [SEL_W-1:0]       in_sel  [NUM_OPND];
   logic [SEL_W-1:0]       s1_sel  [NUM_OPND];
   logic [DATA_W-1:0]      rf_rd   [NUM_OPND];
   logic [DATA_W-1:0]      opnd    [NUM_OPND];
   logic [NUM_OPND-1:0]    hazard;

   logic                   req_accept;
   logic                   s2_ready;
   logic                   stall;
   logic                   s1_advance;

   // writeback on rsp transaction
   logic                   wb_en;
   logic [DATA_W-1:0]      wb_val;
   logic [DATA_W-1:0]      mem_rd_data;

   // s1 execute results
   logic [DATA_W-1:0]      imm1_ext, imm2_ext;
   logic [ADDR_W-1:0]      pc_inc;
   logic [ADDR_W-1:0]      ex_addr;
   logic [MEM_AW-1:0]      mem_idx;
   logic                   ex_store;
   logic [DATA_W-1:0]      ex_store_val;

   // data memory port
   logic                   dm_wr_en;
   logic [MEM_AW-1:0]      dm_wr_addr;
   logic [DATA_W-1:0]      dm_wr_data;

   // ---------------------------------------------------------------------
   // handshake and pipe control
   // ---------------------------------------------------------------------
   assign s2_ready   = !s2_valid_ff || rsp_ready;
   assign stall      = s1_valid_ff && !halt_ff && (|hazard);
   assign s1_advance = s1_valid_ff && !stall && s2_ready;
   assign req_ready  = (state_ff == ST_RUN) && (!s1_valid_ff || s1_advance);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = s2_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   // reset sweep over the data memory
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == MEM_AW'(CLR_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_cnt_in = clr_cnt_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // register file: one copy per operand slot, registers 3 and up only
   // ---------------------------------------------------------------------
   always_comb begin
      in_sel[OPND_A] = req_payload.src_a_sel;
      in_sel[OPND_B] = req_payload.src_b_sel;
      in_sel[OPND_C] = req_payload.src_c_sel;
      in_sel[OPND_D] = req_payload.dest_sel;
      s1_sel[OPND_A] = s1_req_ff.src_a_sel;
      s1_sel[OPND_B] = s1_req_ff.src_b_sel;
      s1_sel[OPND_C] = s1_req_ff.src_c_sel;
      s1_sel[OPND_D] = s1_req_ff.dest_sel;
   end

   for (genvar k = 0; k < NUM_OPND; k++) begin : g_rf
      tocx_ram #(
         .WIDTH (DATA_W),
         .DEPTH (REG_COUNT)
      ) u_rf (
         .clock   (clock),
         .wr_en   (wb_en),
         .wr_addr (s2_rsp_ff.written_reg[RF_AW-1:0]),
         .wr_data (wb_val),
         .rd_en   (req_accept),
         .rd_addr (in_sel[k][RF_AW-1:0]),
         .rd_data (rf_rd[k])
      );
   end

   assign imm1_ext = {{(DATA_W - IMM_W){s1_req_ff.imm_first[IMM_W-1]}}, s1_req_ff.imm_first};
   assign imm2_ext = {{(DATA_W - IMM_W){s1_req_ff.imm_second[IMM_W-1]}},
                      s1_req_ff.imm_second};

   // operand select: fixed registers and out-of-range selects, then the pending
   // s2 result, then a value caught during the read, then the ram copy
   always_comb begin
      for (int k = 0; k < NUM_OPND; k++) begin
         hazard[k] = 1'b0;
         if (s1_sel[k] == REG_ZERO) begin
            opnd[k] = '0;
         end else if (s1_sel[k] == REG_IMM1) begin
            opnd[k] = imm1_ext;
         end else if (s1_sel[k] == REG_IMM2) begin
            opnd[k] = imm2_ext;
         end else if ({1'b0, s1_sel[k]} >= (SEL_W + 1)'(REG_COUNT)) begin
            opnd[k] = '0;
         end else if (s2_valid_ff && s2_rsp_ff.reg_written &&
                      (s2_rsp_ff.written_reg == s1_sel[k])) begin
            // load result not ready until s2 retires
            opnd[k]   = s2_rsp_ff.written_value;
            hazard[k] = s2_is_load_ff;
         end else if (fwd_ff[k]) begin
            opnd[k] = fwd_val_ff[k];
         end else if (rdvld_ff[k]) begin
            opnd[k] = rf_rd[k];
         end else begin
            opnd[k] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // s1 execute
   // ---------------------------------------------------------------------
   assign pc_inc  = pc_ff + 1'b1;
   assign ex_addr = opnd[OPND_A][ADDR_W-1:0] + opnd[OPND_B][ADDR_W-1:0];

   // word index into data memory: address modulo MEM_DEPTH
   if (MEM_DEPTH >= ADDR_SPAN) begin : g_idx_direct
      assign mem_idx = MEM_AW'(ex_addr);
   end else begin : g_idx_mod
      logic [PROD_W-1:0] mod_prod;
      logic [ADDR_W-1:0] mod_quot;
      logic [ADDR_W-1:0] mod_raw;
      // reciprocal estimate is exact or one low, one correction step
      assign mod_prod = PROD_W'(ex_addr) * PROD_W'(MOD_RECIP);
      assign mod_quot = mod_prod[PROD_W-1:MOD_SHIFT];
      assign mod_raw  = ex_addr - ADDR_W'(mod_quot * ADDR_W'(MEM_DEPTH));
      assign mem_idx  = (mod_raw >= ADDR_W'(MEM_DEPTH)) ?
                        MEM_AW'(mod_raw - ADDR_W'(MEM_DEPTH)) : MEM_AW'(mod_raw);
   end

   always_comb begin
      logic [DATA_W-1:0] a, b, c, d;
      logic [DATA_W-1:0] val;
      logic              do_reg, is_ld, is_st, io, bad, writable, take;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] npc;
      logic              nhalt;

      a        = opnd[OPND_A];
      b        = opnd[OPND_B];
      c        = opnd[OPND_C];
      d        = opnd[OPND_D];
      val      = '0;
      do_reg   = 1'b0;
      is_ld    = 1'b0;
      is_st    = 1'b0;
      io       = 1'b0;
      bad      = 1'b0;
      take     = 1'b0;
      addr     = '0;
      npc      = pc_inc;
      nhalt    = 1'b0;
      writable = (s1_req_ff.dest_sel > REG_IMM2) &&
                 ({1'b0, s1_req_ff.dest_sel} < (SEL_W + 1)'(REG_COUNT));

      case (s1_req_ff.op_code)
         OP_ADD:  begin val = a + b + c; do_reg = 1'b1; end
         OP_SUB:  begin val = a - b - c; do_reg = 1'b1; end
         OP_MAC:  begin val = (a * b) + c; do_reg = 1'b1; end
         OP_AND:  begin val = a & b & c; do_reg = 1'b1; end
         OP_OR:   begin val = a | b | c; do_reg = 1'b1; end
         OP_XOR:  begin val = a ^ b ^ c; do_reg = 1'b1; end
         OP_SLL:  begin val = a << b[4:0]; do_reg = 1'b1; end
         OP_SRA:  begin val = DATA_W'($signed(a) >>> b[4:0]); do_reg = 1'b1; end
         OP_SRL:  begin val = a >> b[4:0]; do_reg = 1'b1; end
         OP_BEQ:  begin take = (a == b); end
         OP_BNE:  begin take = (a != b); end
         OP_BLT:  begin take = ($signed(a) < $signed(b)); end
         OP_BGT:  begin take = ($signed(b) < $signed(a)); end
         OP_BLE:  begin take = !($signed(b) < $signed(a)); end
         OP_BGE:  begin take = !($signed(a) < $signed(b)); end
         OP_JAL: begin
            val    = DATA_W'(pc_inc);
            do_reg = 1'b1;
            take   = 1'b1;
         end
         OP_LW: begin
            addr = ex_addr;
            if (writable) begin
               // third operand rides along, load data added in s2
               val    = c;
               do_reg = 1'b1;
               is_ld  = 1'b1;
            end
         end
         OP_SW: begin
            addr  = ex_addr;
            val   = d + c;
            is_st = 1'b1;
         end
         OP_RETI: begin io = 1'b1; npc = pc_ff; end
         OP_IN:   begin io = 1'b1; end
         OP_OUT:  begin io = 1'b1; end
         OP_HALT: begin nhalt = 1'b1; npc = pc_ff; end
         default: begin bad = 1'b1; npc = pc_ff; end
      endcase

      if (take) begin
         npc = c[ADDR_W-1:0];
      end

      s2_rsp_in               = '0;
      s2_is_load_in           = 1'b0;
      ex_store                = 1'b0;
      ex_store_val            = val;
      pc_in                   = pc_ff;
      halt_in                 = halt_ff;
      if (halt_ff) begin
         // sticky halt: item changes nothing
         s2_rsp_in.next_pc = pc_ff;
         s2_rsp_in.halted  = 1'b1;
      end else begin
         s2_rsp_in.next_pc       = npc;
         s2_rsp_in.halted        = nhalt;
         s2_rsp_in.reg_written   = do_reg && writable;
         s2_rsp_in.written_reg   = (do_reg && writable) ? s1_req_ff.dest_sel : '0;
         s2_rsp_in.written_value = ((do_reg && writable) || is_st) ? val : '0;
         s2_rsp_in.mem_written   = is_st;
         s2_rsp_in.mem_address   = addr;
         s2_rsp_in.io_request    = io;
         s2_rsp_in.bad_opcode    = bad;
         s2_is_load_in           = is_ld;
         ex_store                = is_st;
         pc_in                   = npc;
         halt_in                 = nhalt;
      end
   end

   // ---------------------------------------------------------------------
   // data memory: store writes as it leaves s1, load reads as it leaves s1
   // ---------------------------------------------------------------------
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         dm_wr_en   = 1'b1;
         dm_wr_addr = clr_cnt_ff;
         dm_wr_data = '0;
      end else begin
         dm_wr_en   = s1_advance && ex_store;
         dm_wr_addr = mem_idx;
         dm_wr_data = ex_store_val;
      end
   end

   tocx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (s1_advance),
      .rd_addr (mem_idx),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------
   // s2 result and register writeback
   // ---------------------------------------------------------------------
   assign wb_val = s2_is_load_ff ? (mem_rd_data + s2_rsp_ff.written_value) :
                                   s2_rsp_ff.written_value;
   assign wb_en  = s2_valid_ff && rsp_ready && s2_rsp_ff.reg_written;

   always_comb begin
      rsp_payload               = s2_rsp_ff;
      rsp_payload.written_value = wb_val;
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
         rf_vld_ff   <= '0;
         for (int k = 0; k < NUM_OPND; k++) begin
            fwd_ff[k]   <= 1'b0;
            rdvld_ff[k] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_advance) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
         if (wb_en) begin
            rf_vld_ff[s2_rsp_ff.written_reg[RF_AW-1:0]] <= 1'b1;
         end
         // catch a writeback landing on the same edge as the ram read, or
         // while the instruction waits in s1
         for (int k = 0; k < NUM_OPND; k++) begin
            if (req_accept) begin
               fwd_ff[k]   <= wb_en && (s2_rsp_ff.written_reg == in_sel[k]);
               rdvld_ff[k] <= rf_vld_ff[in_sel[k][RF_AW-1:0]];
            end else if (wb_en && (s2_rsp_ff.written_reg == s1_sel[k])) begin
               fwd_ff[k] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      for (int k = 0; k < NUM_OPND; k++) begin
         if (req_accept || (wb_en && (s2_rsp_ff.written_reg == s1_sel[k]))) begin
            fwd_val_ff[k] <= wb_val;
         end
      end
      if (s1_advance) begin
         s2_rsp_ff     <= s2_rsp_in;
         s2_is_load_ff <= s2_is_load_in;
      end
   end

endmodule

// File: src/tocx_checker.sv
// ----------------------------------------------------------------------------
// tocx_checker
// Port-level checks on the result channel of the execute block
// ----------------------------------------------------------------------------
module tocx_checker
   import tocx_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic              rsp_xfer;
   logic              halt_seen_ff;
   logic [ADDR_W-1:0] last_pc_ff;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // last retired pc and sticky halt as seen on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff <= 1'b0;
         last_pc_ff   <= '0;
      end else if (rsp_xfer) begin
         halt_seen_ff <= halt_seen_ff || rsp_payload.halted;
         last_pc_ff   <= rsp_payload.next_pc;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction dropped or changed while stalled");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_payload.halted &&
         (rsp_payload.next_pc == last_pc_ff) && !rsp_payload.reg_written &&
         !rsp_payload.mem_written)
      else $error("instruction after halt changed state");

   a_bad_holds_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_opcode |-> (rsp_payload.next_pc == last_pc_ff) &&
         !rsp_payload.reg_written && !rsp_payload.mem_written)
      else $error("invalid opcode moved pc or wrote state");

   a_write_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.reg_written |-> (rsp_payload.written_reg > REG_IMM2) &&
         !rsp_payload.mem_written && !rsp_payload.io_request)
      else $error("register write to a fixed register or mixed with store");

endmodule

bind three_operand_cpu_execute tocx_checker u_tocx_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
